/* sv/vgarf_pkg.sv */
// types and constants shared by the video gate array register file
`timescale 1ns / 1ps

package vgarf_pkg;

    typedef enum logic [1:0] {
        OP_IO_WRITE   = 2'd0,
        OP_IO_STATUS  = 2'd1,
        OP_MEM_STATUS = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        hblank;
        logic        vblank;
        logic        status_hsync;
        logic        status_vsync;
        logic        tempo_bit;
        logic        mode_switch;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [25:0] display_regs;
        logic        screen_changed;
        logic        border_changed;
        logic        mode_changed;
        logic        gate_changed;
        logic        gate_value;
        logic        scroll_write;
        logic [2:0]  scroll_index;
        logic        vram_ctrl_write;
        logic        vram_ctrl_select;
        logic [7:0]  forwarded_data;
    } rsp_t;

    // low address byte decode
    localparam logic [7:0] ADDR_VRAM_CTRL  = 8'hcc;
    localparam logic [7:0] ADDR_VRAM_MASK  = 8'hfe;
    localparam logic [7:0] ADDR_GATE       = 8'h08;
    localparam logic [7:0] ADDR_MODE       = 8'hce;
    localparam logic [7:0] ADDR_SCROLL     = 8'hcf;
    localparam logic [7:0] ADDR_PALETTE    = 8'hf0;

    // high address byte on the scroll address
    localparam logic [7:0] SUB_SCROLL_FIRST = 8'd1;
    localparam logic [7:0] SUB_SCROLL_LAST  = 8'd5;
    localparam logic [7:0] SUB_BORDER       = 8'd6;

    localparam logic [7:0] PAL_GROUP_FLAG  = 8'h40;
    localparam logic [7:0] STATUS_FIXED    = 8'h7e;

    localparam logic [3:0] MODE_RESET      = 4'h8;
    localparam logic [3:0] PAL_RESET [4]   = '{4'h9, 4'hf, 4'h9, 4'hf};

endpackage

/* sv/vgarf_req_if.sv */
// bus access channel into the register file
`timescale 1ns / 1ps

interface vgarf_req_if;
    logic               valid;
    logic               ready;
    vgarf_pkg::req_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/vgarf_rsp_if.sv */
// result channel out of the register file
`timescale 1ns / 1ps

interface vgarf_rsp_if;
    logic               valid;
    logic               ready;
    vgarf_pkg::rsp_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/video_gate_array_register_file_core.sv */
// Register file of a video gate array: decodes bus writes into the display
// mode, border colour, palette group, four palette entries and the timer gate
// latch, forwards scroll and VRAM format writes, and packs status reads. Each
// item gives one result. An item is captured in an input register, decoded
// against the current register state and written into a result register, so
// one item is taken every clock while results are taken, and a result is
// valid once its item has passed both registers. The result register and the
// input register let a new item in while an earlier result waits to be taken.
// cfg_wr_en writes the status compatibility bit; write it only while the block
// is idle.
`timescale 1ns / 1ps

module video_gate_array_register_file_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    vgarf_req_if.sink    req,
    vgarf_rsp_if.source  rsp
);
    import vgarf_pkg::*;

    // pipeline control
    logic        in_valid_reg;
    req_t        in_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;
    logic        advance;
    logic        accept;

    // register state
    logic        compat_reg;
    logic [3:0]  mode_reg;
    logic [3:0]  mode_next;
    logic [3:0]  border_reg;
    logic [3:0]  border_next;
    logic [1:0]  group_reg;
    logic [1:0]  group_next;
    logic [3:0]  pal_reg  [4];
    logic [3:0]  pal_next [4];
    logic        gate_reg;
    logic        gate_next;

    rsp_t        rsp_next;

    // decode helpers
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        ext_mode;
    logic        mirror;
    logic [1:0]  pal_idx;
    logic [3:0]  pal_we;
    logic        pal_changed;
    logic        group_changed;

    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    assign lo       = in_reg.address[7:0];
    assign hi       = in_reg.address[15:8];
    assign ext_mode = !mode_reg[3];
    assign mirror   = (mode_reg[2:0] == 3'b111);
    assign pal_idx  = in_reg.write_data[5:4];

    // mirror mode: entry 0 also lands in entry 1, entry 3 also in entry 2
    always_comb
    begin
        pal_we[0] = (pal_idx == 2'd0);
        pal_we[1] = (pal_idx == 2'd1) || (mirror && pal_idx == 2'd0);
        pal_we[2] = (pal_idx == 2'd2) || (mirror && pal_idx == 2'd3);
        pal_we[3] = (pal_idx == 2'd3);
    end

    always_comb
    begin
        mode_next   = mode_reg;
        border_next = border_reg;
        group_next  = group_reg;
        gate_next   = gate_reg;
        for (int i = 0; i < 4; i++)
        begin
            pal_next[i] = pal_reg[i];
        end
        rsp_next = '0;

        unique case (op_t'(in_reg.operation))
            OP_IO_STATUS:
            begin
                rsp_next.read_data = {in_reg.hblank, in_reg.vblank, in_reg.status_hsync,
                                      in_reg.status_vsync, 2'b00, in_reg.mode_switch,
                                      in_reg.tempo_bit};
            end
            OP_MEM_STATUS:
            begin
                rsp_next.read_data = (compat_reg ? STATUS_FIXED : 8'h00)
                                   | {in_reg.hblank, 6'b000000, in_reg.tempo_bit};
            end
            OP_IO_WRITE:
            begin
                priority if ((lo & ADDR_VRAM_MASK) == ADDR_VRAM_CTRL)
                begin
                    rsp_next.vram_ctrl_write  = 1'b1;
                    rsp_next.vram_ctrl_select = lo[0];
                    rsp_next.forwarded_data   = in_reg.write_data;
                end
                else if (lo == ADDR_GATE)
                begin
                    gate_next = in_reg.write_data[0];
                end
                else if (lo == ADDR_MODE)
                begin
                    mode_next = in_reg.write_data[3:0];
                end
                else if (lo == ADDR_SCROLL)
                begin
                    if (hi >= SUB_SCROLL_FIRST && hi <= SUB_SCROLL_LAST)
                    begin
                        rsp_next.scroll_write   = 1'b1;
                        rsp_next.scroll_index   = hi[2:0];
                        rsp_next.forwarded_data = in_reg.write_data;
                    end
                    else if (hi == SUB_BORDER)
                    begin
                        border_next = in_reg.write_data[3:0];
                    end
                end
                else if (lo == ADDR_PALETTE)
                begin
                    if ((in_reg.write_data & PAL_GROUP_FLAG) != 8'h00)
                    begin
                        group_next = in_reg.write_data[1:0];
                    end
                    else
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            if (pal_we[i])
                            begin
                                pal_next[i] = in_reg.write_data[3:0];
                            end
                        end
                    end
                end
            end
            OP_NONE:
            begin
                rsp_next.read_data = 8'h00;
            end
            default:
            begin
                rsp_next.read_data = 8'h00;
            end
        endcase

        pal_changed   = (pal_next[0] != pal_reg[0]) || (pal_next[1] != pal_reg[1])
                     || (pal_next[2] != pal_reg[2]) || (pal_next[3] != pal_reg[3]);
        group_changed = (group_next != group_reg);

        rsp_next.mode_changed   = (mode_next != mode_reg);
        rsp_next.border_changed = (border_next != border_reg);
        rsp_next.gate_changed   = (gate_next != gate_reg);
        rsp_next.gate_value     = gate_next;
        rsp_next.screen_changed = rsp_next.mode_changed
                               || (ext_mode && (pal_changed || group_changed));
        rsp_next.display_regs   = {pal_next[3], pal_next[2], pal_next[1], pal_next[0],
                                   group_next, border_next, mode_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            compat_reg    <= 1'b0;
            mode_reg      <= MODE_RESET;
            border_reg    <= 4'h0;
            group_reg     <= 2'b00;
            gate_reg      <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                pal_reg[i] <= PAL_RESET[i];
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                compat_reg <= cfg_wr_data;
            end
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                border_reg    <= border_next;
                group_reg     <= group_next;
                gate_reg      <= gate_next;
                for (int i = 0; i < 4; i++)
                begin
                    pal_reg[i] <= pal_next[i];
                end
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= req.payload;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
